// File: hw/rtl/nrb_pkg.sv
// nrb_pkg: shared constants, register indexes and controller/datapath structs
`timescale 1ns / 1ps

package nrb_pkg;

  // number format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int MAG_BITS  = WORD_BITS - 1;
  localparam int PROD_BITS = MAG_BITS + WORD_BITS;

  // field widths fixed by the interface
  localparam int TGT_BITS  = 32;
  localparam int EXP_BITS  = 5;
  localparam int TOL_BITS  = 32;
  localparam int STEP_BITS = 6;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  // compare widths
  localparam int DIFF_CMP_BITS = ((WORD_BITS > TOL_BITS) ? WORD_BITS : TOL_BITS) + 2;
  localparam int PWR_CMP_BITS  = ((WORD_BITS > TGT_BITS) ? WORD_BITS : TGT_BITS) + 2;

  localparam logic [STEP_BITS-1:0] STEP_LIMIT = '1;
  localparam logic [STEP_BITS-1:0] STEP_MAX   = STEP_BITS'(WORD_BITS + 1);

  localparam logic [MAG_BITS-1:0] MAG_MAX = '1;
  localparam logic [MAG_BITS-1:0] ONE_MAG = MAG_BITS'(1) << FRAC_BITS;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE = CFG_INDEX_BITS'(1);

  localparam logic [EXP_BITS-1:0] EXPONENT_RESET  = EXP_BITS'(2);
  localparam logic [TOL_BITS-1:0] TOLERANCE_RESET = TOL_BITS'(1);

  typedef struct packed {
    logic load;      // take a new transaction
    logic start_lo;  // start the power of the low end
    logic take_mid;  // new midpoint, start its power
    logic mul;       // one multiply of the running power
    logic latch_sl;  // store the sign for the low end
    logic resolve;   // move one interval end to the midpoint
    logic out_load;  // capture the result
  } nrb_cmd_t;

  typedef struct packed {
    logic cont;        // interval still wider than tolerance, step limit not reached
    logic pow_done;    // running power has all its factors
    logic first_step;  // no bisection step taken yet
  } nrb_status_t;

endpackage

// File: hw/rtl/nrb_if.sv
// nrb_if: request, result and configuration channel interfaces
`timescale 1ns / 1ps

interface nrb_req_if;
  logic                                valid;
  logic                                ready;
  logic [nrb_pkg::TGT_BITS-1:0]        target;
  logic signed [nrb_pkg::WORD_BITS-1:0] lower_bound;
  logic signed [nrb_pkg::WORD_BITS-1:0] upper_bound;

  modport source (output valid, target, lower_bound, upper_bound, input ready);
  modport sink (input valid, target, lower_bound, upper_bound, output ready);
endinterface

interface nrb_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [nrb_pkg::WORD_BITS-1:0] root;
  logic [nrb_pkg::STEP_BITS-1:0]        iterations;

  modport source (output valid, root, iterations, input ready);
  modport sink (input valid, root, iterations, output ready);
endinterface

interface nrb_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [nrb_pkg::CFG_INDEX_BITS-1:0] index;
  logic [nrb_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/nrb_datapath.sv
// nrb_datapath: interval registers, shared multiplier, power and sign compare
`timescale 1ns / 1ps

module nrb_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  nrb_pkg::nrb_cmd_t                     cmd,
  output nrb_pkg::nrb_status_t                  status,
  input  logic                                  cfg_write,
  input  logic [nrb_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [nrb_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic [nrb_pkg::TGT_BITS-1:0]          target,
  input  logic signed [nrb_pkg::WORD_BITS-1:0]  lower_bound,
  input  logic signed [nrb_pkg::WORD_BITS-1:0]  upper_bound,
  output logic signed [nrb_pkg::WORD_BITS-1:0]  root,
  output logic [nrb_pkg::STEP_BITS-1:0]         iterations
);

  // configuration
  logic [nrb_pkg::EXP_BITS-1:0] exponent;
  logic [nrb_pkg::TOL_BITS-1:0] tolerance;

  // interval and item state
  logic signed [nrb_pkg::WORD_BITS-1:0] lo;
  logic signed [nrb_pkg::WORD_BITS-1:0] hi;
  logic signed [nrb_pkg::WORD_BITS-1:0] mid;
  logic [nrb_pkg::TGT_BITS-1:0]         tgt;
  logic [nrb_pkg::STEP_BITS-1:0]        steps;
  logic                                 sl_gt;
  logic                                 sl_lt;

  // power unit
  logic [nrb_pkg::WORD_BITS-1:0] xmag;
  logic                          xneg;
  logic [nrb_pkg::PROD_BITS-1:0] prod;
  logic                          first;
  logic [nrb_pkg::EXP_BITS-1:0]  cnt;

  logic signed [nrb_pkg::WORD_BITS:0]         sum;
  logic signed [nrb_pkg::WORD_BITS-1:0]       mid_next;
  logic [nrb_pkg::WORD_BITS-1:0]              x_sel;
  logic [nrb_pkg::WORD_BITS-1:0]              xmag_next;
  logic signed [nrb_pkg::WORD_BITS:0]         diff;
  logic signed [nrb_pkg::DIFF_CMP_BITS-1:0]   diff_ext;
  logic signed [nrb_pkg::DIFF_CMP_BITS-1:0]   tol_ext;
  logic [nrb_pkg::TOL_BITS-1:0]               tol_eff;
  logic [nrb_pkg::MAG_BITS-1:0]               clamp_mag;
  logic [nrb_pkg::MAG_BITS-1:0]               acc_mag;
  logic                                       pw_neg;
  logic [nrb_pkg::WORD_BITS-1:0]              pw_mag;
  logic signed [nrb_pkg::WORD_BITS-1:0]       pw;
  logic signed [nrb_pkg::PWR_CMP_BITS-1:0]    pw_ext;
  logic signed [nrb_pkg::PWR_CMP_BITS-1:0]    t_ext;
  logic                                       pw_gt;
  logic                                       pw_lt;
  logic                                       same_sign;
  logic [nrb_pkg::PROD_BITS-1:0]              prod_next;

  // floor of the mean: the carry bit keeps the sum exact
  assign sum      = (nrb_pkg::WORD_BITS + 1)'(lo) + (nrb_pkg::WORD_BITS + 1)'(hi);
  assign mid_next = sum[nrb_pkg::WORD_BITS:1];

  assign x_sel     = cmd.take_mid ? mid_next : lo;
  assign xmag_next = x_sel[nrb_pkg::WORD_BITS-1] ? (~x_sel + nrb_pkg::WORD_BITS'(1)) : x_sel;

  assign tol_eff  = (tolerance == '0) ? nrb_pkg::TOL_BITS'(1) : tolerance;
  assign diff     = (nrb_pkg::WORD_BITS + 1)'(hi) - (nrb_pkg::WORD_BITS + 1)'(lo);
  assign diff_ext = nrb_pkg::DIFF_CMP_BITS'(diff);
  assign tol_ext  = nrb_pkg::DIFF_CMP_BITS'(tol_eff);

  // truncated product magnitude, saturated to the word limit
  assign clamp_mag =
    (prod[nrb_pkg::PROD_BITS-1:nrb_pkg::FRAC_BITS+nrb_pkg::MAG_BITS] != '0) ?
    nrb_pkg::MAG_MAX :
    prod[nrb_pkg::FRAC_BITS+nrb_pkg::MAG_BITS-1:nrb_pkg::FRAC_BITS];
  assign acc_mag   = first ? nrb_pkg::ONE_MAG : clamp_mag;
  assign prod_next = acc_mag * xmag;

  // sign flips once per negative factor, so odd exponents keep it
  assign pw_neg = xneg & exponent[0] & (acc_mag != '0);
  assign pw_mag = {1'b0, acc_mag};
  assign pw     = pw_neg ? (~pw_mag + nrb_pkg::WORD_BITS'(1)) : pw_mag;
  assign pw_ext = nrb_pkg::PWR_CMP_BITS'(pw);
  assign t_ext  = nrb_pkg::PWR_CMP_BITS'(tgt);
  assign pw_gt  = pw_ext > t_ext;
  assign pw_lt  = pw_ext < t_ext;

  // sign product of low and mid residuals is positive
  assign same_sign = (sl_gt & pw_gt) | (sl_lt & pw_lt);

  assign status.cont       = (diff_ext > tol_ext) && (steps != nrb_pkg::STEP_LIMIT);
  assign status.pow_done   = (cnt == exponent);
  assign status.first_step = (steps == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent  <= nrb_pkg::EXPONENT_RESET;
      tolerance <= nrb_pkg::TOLERANCE_RESET;
    end else if (cfg_write) begin
      if (cfg_index == nrb_pkg::REG_EXPONENT) begin
        exponent <= cfg_data[nrb_pkg::EXP_BITS-1:0];
      end else if (cfg_index == nrb_pkg::REG_TOLERANCE) begin
        tolerance <= cfg_data[nrb_pkg::TOL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo    <= lower_bound;
      hi    <= upper_bound;
      mid   <= lower_bound;
      tgt   <= target;
      steps <= '0;
    end
    if (cmd.take_mid) begin
      mid   <= mid_next;
      steps <= steps + nrb_pkg::STEP_BITS'(1);
    end
    if (cmd.start_lo || cmd.take_mid) begin
      xmag  <= xmag_next;
      xneg  <= x_sel[nrb_pkg::WORD_BITS-1];
      first <= 1'b1;
      cnt   <= '0;
    end
    if (cmd.mul) begin
      prod  <= prod_next;
      first <= 1'b0;
      cnt   <= cnt + nrb_pkg::EXP_BITS'(1);
    end
    if (cmd.latch_sl) begin
      sl_gt <= pw_gt;
      sl_lt <= pw_lt;
    end
    if (cmd.resolve) begin
      // low end moves when both residuals share a sign, and its sign is unchanged
      if (same_sign) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.out_load) begin
      root       <= mid;
      iterations <= steps;
    end
  end

endmodule

// File: hw/rtl/nrb_ctrl.sv
// nrb_ctrl: sequencer for bisection steps and power evaluation
`timescale 1ns / 1ps

module nrb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  nrb_pkg::nrb_status_t status,
  output nrb_pkg::nrb_cmd_t    cmd
);

  typedef enum logic [3:0] {
    IDLE    = 4'b0001,
    CHECK   = 4'b0010,
    POW_LO  = 4'b0100,
    POW_MID = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        if (!status.cont) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_next   = IDLE;
          end
        end else if (status.first_step) begin
          cmd.start_lo = 1'b1;
          state_next   = POW_LO;
        end else begin
          cmd.take_mid = 1'b1;
          state_next   = POW_MID;
        end
      end
      POW_LO: begin
        if (status.pow_done) begin
          cmd.latch_sl = 1'b1;
          cmd.take_mid = 1'b1;
          state_next   = POW_MID;
        end else begin
          cmd.mul = 1'b1;
        end
      end
      POW_MID: begin
        if (status.pow_done) begin
          cmd.resolve = 1'b1;
          state_next  = CHECK;
        end else begin
          cmd.mul = 1'b1;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/nth_root_bisection.sv
// nth_root_bisection: top level, fixed-point nth root by interval bisection
`timescale 1ns / 1ps

// Finds a root of x^n - target on [lower_bound, upper_bound] by bisection in
// signed Q16.16, halving the interval until its width is at most the
// tolerance register (zero acts as one), and returns the last midpoint with
// the step count; an empty or reversed interval returns lower_bound and zero
// steps. One transaction is worked on at a time. A single shared multiplier
// does one saturating multiply per cycle; a bisection step takes a new
// midpoint, raises it to the power n and moves one interval end. The low
// end power is evaluated once, since its residual sign carries over between
// steps. A full range interval needs up to 32 steps. The result sits in an
// output register, so the next request can be taken and worked on while
// a stalled result waits; configuration writes are always ready, and the
// user must apply them only while idle, since the block does not enforce it.
module nth_root_bisection (
  input logic       clk,
  input logic       rst,
  nrb_req_if.sink   request,
  nrb_res_if.source result,
  nrb_cfg_if.sink   cfg
);

  nrb_pkg::nrb_cmd_t    cmd;
  nrb_pkg::nrb_status_t status;

  assign cfg.ready = 1'b1;

  nrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  nrb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_write   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .target      (request.target),
    .lower_bound (request.lower_bound),
    .upper_bound (request.upper_bound),
    .root        (result.root),
    .iterations  (result.iterations)
  );

`ifndef ASSERT_OFF
  // the halving bounds the step count for any interval in the word
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.iterations <= nrb_pkg::STEP_MAX))
    else $error("step count beyond the interval halving bound");

  // a taken request leaves the block busy in the cycle after it is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !request.ready)
    else $error("request taken again right after a transaction");

  // a result cannot appear in the cycle right after a request is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready) |=> !$rose(result.valid))
    else $error("result raised without an interval check");
`endif

endmodule

// File: tb/sv/nth_root_bisection_tb.sv
// nth_root_bisection_tb: self-checking testbench for the bisection root finder
`timescale 1ns / 1ps

module nth_root_bisection_tb;
  import nrb_pkg::*;

  localparam int QUIET_LIMIT   = 10000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS  = 860;
  localparam int BURST_ITEMS   = 100;

  // indexes past the two registers, writes there must change nothing
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = CFG_INDEX_BITS'(3);

  typedef struct packed {
    logic signed [WORD_BITS-1:0] root;
    logic [STEP_BITS-1:0]        iterations;
  } root_result_t;

  logic clk = 1'b0;
  logic rst;

  nrb_req_if req_ch ();
  nrb_res_if res_ch ();
  nrb_cfg_if cfg_ch ();

  nth_root_bisection dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [EXP_BITS-1:0] exponent_setting  = EXPONENT_RESET;
  logic [TOL_BITS-1:0] tolerance_setting = TOLERANCE_RESET;
  root_result_t        pending_roots[$];
  int                  error_count = 0;
  bit                  idle_on     = 1'b1;
  int                  stall_left  = 0;

  // |acc| * |x| scaled back to the fraction point, magnitude saturated
  function automatic logic [MAG_BITS-1:0] scaled_product(logic [MAG_BITS-1:0] acc,
                                                         logic [WORD_BITS-1:0] xm);
    logic [63:0] prod;
    prod = 64'(acc) * 64'(xm);
    prod = prod >> FRAC_BITS;
    if (prod > 64'(MAG_MAX)) return MAG_MAX;
    return prod[MAG_BITS-1:0];
  endfunction

  function automatic longint fixed_power(logic signed [WORD_BITS-1:0] x);
    logic [MAG_BITS-1:0]  mag;
    logic [WORD_BITS-1:0] xm;
    logic                 neg;
    mag = ONE_MAG;
    neg = 1'b0;
    xm  = x[WORD_BITS-1] ? -x : x;
    for (int i = 0; i < exponent_setting; i++) begin
      mag = scaled_product(mag, xm);
      neg = neg ^ x[WORD_BITS-1];
    end
    return (neg && mag != '0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic int residual_sign(logic signed [WORD_BITS-1:0] x,
                                       logic [TGT_BITS-1:0] t);
    longint p;
    p = fixed_power(x);
    if (p > longint'(t)) return 1;
    if (p < longint'(t)) return -1;
    return 0;
  endfunction

  function automatic root_result_t bisect(logic [TGT_BITS-1:0] t,
                                          logic signed [WORD_BITS-1:0] lo_in,
                                          logic signed [WORD_BITS-1:0] hi_in);
    longint       lo, hi, mid, tol;
    int           steps;
    int           sl, sm;
    root_result_t r;
    lo    = lo_in;
    hi    = hi_in;
    tol   = (tolerance_setting == '0) ? 1 : longint'(tolerance_setting);
    mid   = lo;
    steps = 0;
    while (hi - lo > tol && steps < 63) begin
      mid = (lo + hi) >>> 1;
      steps++;
      sl = residual_sign(lo[WORD_BITS-1:0], t);
      sm = residual_sign(mid[WORD_BITS-1:0], t);
      if (sl * sm <= 0) begin
        hi = mid;
      end else begin
        lo = mid;
      end
    end
    r.root       = mid[WORD_BITS-1:0];
    r.iterations = steps[STEP_BITS-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // result side: random stall bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left   <= $urandom_range(0, 6);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    root_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_roots.size() == 0) begin
        report_mismatch($sformatf("result root=%0d iterations=%0d with nothing pending",
                                  res_ch.root, res_ch.iterations));
      end else begin
        want = pending_roots.pop_front();
        if (res_ch.root !== want.root)
          report_mismatch($sformatf("root got %0d expected %0d", res_ch.root, want.root));
        if (res_ch.iterations !== want.iterations)
          report_mismatch($sformatf("iterations got %0d expected %0d",
                                    res_ch.iterations, want.iterations));
      end
    end
  end

  // watchdog: too long without any transaction on any channel
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_request(input logic [TGT_BITS-1:0] t,
                              input logic signed [WORD_BITS-1:0] lo,
                              input logic signed [WORD_BITS-1:0] hi);
    if (cfg_ch.valid) cfg_ch.valid <= 1'b0;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      if (req_ch.valid) req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.target      <= t;
    req_ch.lower_bound <= lo;
    req_ch.upper_bound <= hi;
    do @(posedge clk); while (!req_ch.ready);
    pending_roots.push_back(bisect(t, lo, hi));
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_EXPONENT:  exponent_setting = value[EXP_BITS-1:0];
      REG_TOLERANCE: tolerance_setting = value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    if (req_ch.valid) req_ch.valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_BITS-1:0] exp_word,
                            input logic [TOL_BITS-1:0] tol);
    wait_idle();
    write_reg(REG_EXPONENT, exp_word);
    write_reg(REG_TOLERANCE, tol);
  endtask

  task automatic send_random_item();
    logic [TGT_BITS-1:0]         t;
    logic signed [WORD_BITS-1:0] a, b, tmp;
    int                          kind;
    kind = $urandom_range(0, 9);
    t    = $urandom() >> $urandom_range(0, 31);
    a    = $signed($urandom()) >>> $urandom_range(0, 31);
    b    = $signed($urandom()) >>> $urandom_range(0, 31);
    if (kind <= 6) begin
      // ordered interval, often starting at zero so a real root sits inside
      if (kind <= 2) a = '0;
      if (a > b) begin
        tmp = a;
        a   = b;
        b   = tmp;
      end
    end else if (kind == 7) begin
      if (a < b) begin
        tmp = a;
        a   = b;
        b   = tmp;
      end
    end else begin
      t = $urandom();
      a = $urandom();
      b = $urandom();
    end
    send_request(t, a, b);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] random_exponent_word();
    logic [EXP_BITS-1:0] n;
    int                  pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) n = '0;
    else if (pick == 1) n = EXP_BITS'($urandom_range(17, 31));
    else n = EXP_BITS'($urandom_range(1, 16));
    return {(CFG_DATA_BITS - EXP_BITS)'($urandom()), n};
  endfunction

  function automatic logic [TOL_BITS-1:0] random_tolerance();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2, 3:    return $urandom();
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  task automatic test_directed();
    // reset settings: square root, tolerance one
    send_request(32'h0002_0000, 32'sh0000_0000, 32'sh0002_0000);
    send_request(32'h0000_0000, 32'sh0000_0000, 32'sh0001_0000);
    send_request(32'hFFFF_FFFF, 32'sh0000_0000, 32'sh7FFF_FFFF);
    send_request(32'h0004_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_request(32'h0001_0000, 32'sh0003_0000, 32'sh0003_0000);
    send_request(32'h0001_0000, 32'sh0005_0000, 32'sh0001_0000);
    send_request(32'h0001_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_request(32'h0001_0000, 32'sh0000_0064, 32'sh0000_0065);
    // odd power over a negative range, zero tolerance acts as one
    set_config(32'd3, 32'd0);
    send_request(32'h0008_0000, 32'shFFFC_0000, 32'sh0004_0000);
    send_request(32'h0000_0000, 32'sh8000_0000, 32'sh0000_0001);
    // power of zero is the constant one
    set_config(32'd0, 32'd1);
    send_request(32'h0001_0000, 32'shFFFF_0000, 32'sh0001_0000);
    send_request(32'h0000_8000, 32'sh0000_0000, 32'sh0010_0000);
    set_config(32'd1, 32'd16);
    send_request(32'h0003_0000, 32'sh0000_0000, 32'sh0003_0000);
    send_request(32'h8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    set_config(32'd16, 32'd1);
    send_request(32'hFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_request(32'h0001_8000, 32'sh0000_0000, 32'sh0002_0000);
    // exponent above sixteen, upper data bits ignored
    set_config(32'hFFFF_FFFF, 32'd1);
    send_request(32'h0000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_request(32'h7FFF_FFFF, 32'sh0000_0000, 32'sh0002_0000);
    // widest tolerance: the full range just fits within it and needs no step
    set_config(32'd2, 32'hFFFF_FFFF);
    send_request(32'h0004_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    set_config(32'd2, 32'hFFFF_FFFE);
    send_request(32'h0004_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
  endtask

  task automatic test_spare_index();
    set_config(32'd5, 32'd64);
    write_reg(REG_SPARE_A, $urandom());
    write_reg(REG_SPARE_B, $urandom());
    repeat (6) send_random_item();
  endtask

  task automatic test_random(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      set_config(random_exponent_word(), random_tolerance());
      repeat ($urandom_range(20, 60)) begin
        send_random_item();
        sent++;
      end
    end
  endtask

  task automatic test_back_to_back();
    wait_idle();
    idle_on = 1'b0;
    set_config(32'($urandom_range(1, 16)), 32'($urandom_range(1, 256)));
    repeat (BURST_ITEMS) send_random_item();
  endtask

  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.target      <= '0;
    req_ch.lower_bound <= '0;
    req_ch.upper_bound <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_spare_index();
    test_random(RANDOM_ITEMS);
    test_back_to_back();

    wait_idle();
    if (cfg_ch.valid) cfg_ch.valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/nrb_pkg.sv
hw/rtl/nrb_if.sv
hw/rtl/nrb_datapath.sv
hw/rtl/nrb_ctrl.sv
hw/rtl/nth_root_bisection.sv
tb/sv/nth_root_bisection_tb.sv
